[rtl/assert_macros.svh]
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/dpcs_pkg.sv]
// ----------------------------------------------------------------------------
// dpcs_pkg
// Types, codes and constants of the disk plane crossing stop block.
// ----------------------------------------------------------------------------
package dpcs_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_ROT_INIT,
        S_ROT_RUN,
        S_ROT_SAVE,
        S_MUL,
        S_MUL_WB,
        S_DIV_INIT,
        S_DIV_RUN,
        S_DIV_SAVE,
        S_VEC_INIT,
        S_VEC_RUN,
        S_CROSS,
        S_PUB
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FRESH,
        OP_PLAIN,
        OP_ROT_INIT,
        OP_ROT_STEP,
        OP_ROT_SAVE,
        OP_MUL,
        OP_MUL_WB,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_SAVE,
        OP_VEC_INIT,
        OP_VEC_STEP,
        OP_CROSS,
        OP_PUB
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] ang_sel;
        logic [3:0] mul_sel;
        logic [4:0] step;
    } t_cmd;

    typedef struct packed {
        logic fresh;
        logic crossing;
    } t_status;

    // angle slots
    localparam logic [1:0] ANG_LAST_POLAR = 2'd0;
    localparam logic [1:0] ANG_LAST_AZ    = 2'd1;
    localparam logic [1:0] ANG_POLAR      = 2'd2;
    localparam logic [1:0] ANG_AZ         = 2'd3;

    // multiply sequence
    localparam logic [3:0] MUL_RS_OLD  = 4'd0;
    localparam logic [3:0] MUL_XO      = 4'd1;
    localparam logic [3:0] MUL_YO      = 4'd2;
    localparam logic [3:0] MUL_ZO      = 4'd3;
    localparam logic [3:0] MUL_RS_NEW  = 4'd4;
    localparam logic [3:0] MUL_XN      = 4'd5;
    localparam logic [3:0] MUL_YN      = 4'd6;
    localparam logic [3:0] MUL_ZN      = 4'd7;
    localparam logic [3:0] MUL_PXN     = 4'd8;
    localparam logic [3:0] MUL_XZ      = 4'd9;
    localparam logic [3:0] MUL_PYN     = 4'd10;
    localparam logic [3:0] MUL_YZ      = 4'd11;
    localparam logic [3:0] MUL_MAG_HI  = 4'd12;
    localparam logic [3:0] MUL_MAG_LO  = 4'd13;

    // register indexes
    localparam logic [1:0] REG_OUTER   = 2'd0;
    localparam logic [1:0] REG_INNER   = 2'd1;
    localparam logic [1:0] REG_HORIZON = 2'd2;

    localparam logic [4:0] CORDIC_LAST = 5'd23;
    localparam logic [4:0] DIV_LAST    = 5'd30;

    localparam logic [34:0]        INV_GAIN    = 35'd652032874;
    localparam logic signed [32:0] Q30_Z       = 33'sd1073741824;
    localparam logic signed [32:0] HALF_Z      = 33'sd2147483648;
    localparam logic signed [53:0] Q30_W       = 54'sd1073741824;
    localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
    localparam logic [30:0]        ONE_DZ      = 31'd1073741824;
    localparam logic [31:0]        FREE_LIMIT  = 32'd65536000;
    localparam logic [31:0]        NONE_RADIUS = 32'hFFFF_FFFF;
    localparam logic [31:0]        HALF_TURN   = 32'h8000_0000;

    localparam logic [31:0] OUTER_RESET   = 32'd65536000;
    localparam logic [15:0] INNER_RESET   = 16'd256;
    localparam logic [31:0] HORIZON_RESET = 32'd131072;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/dpcs_if.sv]
// ----------------------------------------------------------------------------
// dpcs interfaces
// Input step channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface dpcs_in_if;
    logic        valid;
    logic        ready;
    logic        new_ray;
    logic [31:0] radius;
    logic [31:0] polar_angle;
    logic [31:0] azimuth;
    logic        moving_inward;

    modport source (output valid, new_ray, radius, polar_angle, azimuth, moving_inward,
                    input ready);
    modport sink   (input valid, new_ray, radius, polar_angle, azimuth, moving_inward,
                    output ready);
endinterface

interface dpcs_out_if;
    logic               valid;
    logic               ready;
    logic               stop;
    logic [1:0]         crossing_total;
    logic [31:0]        above_hit_radius;
    logic signed [31:0] above_hit_azimuth;
    logic [31:0]        below_hit_radius;
    logic signed [31:0] below_hit_azimuth;

    modport source (output valid, stop, crossing_total, above_hit_radius,
                    above_hit_azimuth, below_hit_radius, below_hit_azimuth,
                    input ready);
    modport sink   (input valid, stop, crossing_total, above_hit_radius,
                    above_hit_azimuth, below_hit_radius, below_hit_azimuth,
                    output ready);
endinterface

interface dpcs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/dpcs_ctrl.sv]
// ----------------------------------------------------------------------------
// dpcs_ctrl
// Sequencer: walks each crossing step word through trig, multiply, divide and
// vectoring passes of the datapath, publishes every word and owns both handshakes.
// ----------------------------------------------------------------------------
module dpcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  dpcs_pkg::t_status i_status,
    output dpcs_pkg::t_cmd    o_cmd
);

    dpcs_pkg::t_state r_state, n_state;
    logic [1:0] r_ang, n_ang;
    logic [3:0] r_mul, n_mul;
    logic [4:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dpcs_pkg::S_IDLE;
            r_ang       <= '0;
            r_mul       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ang       <= n_ang;
            r_mul       <= n_mul;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_ang         = r_ang;
        n_mul         = r_mul;
        n_step        = r_step;
        o_in_ready    = 1'b0;
        o_cmd.op      = dpcs_pkg::OP_NONE;
        o_cmd.ang_sel = r_ang;
        o_cmd.mul_sel = r_mul;
        o_cmd.step    = r_step;
        unique case (r_state)
            dpcs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = dpcs_pkg::OP_LOAD;
                    n_state  = dpcs_pkg::S_DECIDE;
                end
            end
            dpcs_pkg::S_DECIDE: begin
                if (i_status.fresh) begin
                    o_cmd.op = dpcs_pkg::OP_FRESH;
                    n_state  = dpcs_pkg::S_PUB;
                end else if (!i_status.crossing) begin
                    o_cmd.op = dpcs_pkg::OP_PLAIN;
                    n_state  = dpcs_pkg::S_PUB;
                end else begin
                    n_ang   = dpcs_pkg::ANG_LAST_POLAR;
                    n_state = dpcs_pkg::S_ROT_INIT;
                end
            end
            dpcs_pkg::S_ROT_INIT: begin
                o_cmd.op = dpcs_pkg::OP_ROT_INIT;
                n_step   = '0;
                n_state  = dpcs_pkg::S_ROT_RUN;
            end
            dpcs_pkg::S_ROT_RUN: begin
                o_cmd.op = dpcs_pkg::OP_ROT_STEP;
                if (r_step == dpcs_pkg::CORDIC_LAST) begin
                    n_state = dpcs_pkg::S_ROT_SAVE;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            dpcs_pkg::S_ROT_SAVE: begin
                o_cmd.op = dpcs_pkg::OP_ROT_SAVE;
                n_ang    = r_ang + 2'd1;
                if (r_ang == dpcs_pkg::ANG_AZ) begin
                    n_mul   = dpcs_pkg::MUL_RS_OLD;
                    n_state = dpcs_pkg::S_MUL;
                end else begin
                    n_state = dpcs_pkg::S_ROT_INIT;
                end
            end
            dpcs_pkg::S_MUL: begin
                o_cmd.op = dpcs_pkg::OP_MUL;
                n_state  = dpcs_pkg::S_MUL_WB;
            end
            dpcs_pkg::S_MUL_WB: begin
                o_cmd.op = dpcs_pkg::OP_MUL_WB;
                n_mul    = r_mul + 4'd1;
                if (r_mul == dpcs_pkg::MUL_ZN) begin
                    n_state = dpcs_pkg::S_DIV_INIT;
                end else if (r_mul == dpcs_pkg::MUL_YZ) begin
                    n_state = dpcs_pkg::S_VEC_INIT;
                end else if (r_mul == dpcs_pkg::MUL_MAG_LO) begin
                    n_state = dpcs_pkg::S_CROSS;
                end else begin
                    n_state = dpcs_pkg::S_MUL;
                end
            end
            dpcs_pkg::S_DIV_INIT: begin
                o_cmd.op = dpcs_pkg::OP_DIV_INIT;
                n_step   = '0;
                n_state  = dpcs_pkg::S_DIV_RUN;
            end
            dpcs_pkg::S_DIV_RUN: begin
                o_cmd.op = dpcs_pkg::OP_DIV_STEP;
                if (r_step == dpcs_pkg::DIV_LAST) begin
                    n_state = dpcs_pkg::S_DIV_SAVE;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            dpcs_pkg::S_DIV_SAVE: begin
                o_cmd.op = dpcs_pkg::OP_DIV_SAVE;
                n_state  = dpcs_pkg::S_MUL;
            end
            dpcs_pkg::S_VEC_INIT: begin
                o_cmd.op = dpcs_pkg::OP_VEC_INIT;
                n_step   = '0;
                n_state  = dpcs_pkg::S_VEC_RUN;
            end
            dpcs_pkg::S_VEC_RUN: begin
                o_cmd.op = dpcs_pkg::OP_VEC_STEP;
                if (r_step == dpcs_pkg::CORDIC_LAST) begin
                    n_state = dpcs_pkg::S_MUL;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            dpcs_pkg::S_CROSS: begin
                o_cmd.op = dpcs_pkg::OP_CROSS;
                n_state  = dpcs_pkg::S_PUB;
            end
            dpcs_pkg::S_PUB: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op = dpcs_pkg::OP_PUB;
                    n_state  = dpcs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dpcs_pkg::S_IDLE;
            end
        endcase
        if (o_cmd.op == dpcs_pkg::OP_PUB) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/dpcs_dp.sv]
// ----------------------------------------------------------------------------
// dpcs_dp
// Datapath: ray state, shared CORDIC, shared multiplier, restoring divider,
// crossing recorder, stop test and result register.
// ----------------------------------------------------------------------------
module dpcs_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dpcs_pkg::t_cmd     i_cmd,
    output dpcs_pkg::t_status  o_status,
    input  logic               i_new_ray,
    input  logic [31:0]        i_radius,
    input  logic [31:0]        i_polar_angle,
    input  logic [31:0]        i_azimuth,
    input  logic               i_moving_inward,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_stop,
    output logic [1:0]         o_crossing_total,
    output logic [31:0]        o_above_hit_radius,
    output logic signed [31:0] o_above_hit_azimuth,
    output logic [31:0]        o_below_hit_radius,
    output logic signed [31:0] o_below_hit_azimuth
);

    // configuration
    logic [31:0] r_outer;
    logic [15:0] r_inner_scale;
    logic [31:0] r_horizon;
    logic [47:0] r_inner_lim;

    // ray state
    logic        r_started;
    logic [1:0]  r_count;
    logic [31:0] r_last_r, r_last_th, r_last_ph;
    logic [31:0] r_above_r, r_above_a, r_below_r, r_below_a;

    // current word
    logic        r_fresh, r_inward;
    logic [31:0] r_r, r_th, r_ph;

    // cordic
    logic signed [53:0] r_cx, r_cy;
    logic signed [32:0] r_cz;
    logic               r_flip, r_exact;
    logic [1:0]         r_quad;
    logic signed [31:0] r_cos [4];
    logic signed [31:0] r_sin [4];

    // multiply and interpolation
    logic signed [69:0] r_prod;
    logic signed [65:0] r_acc;
    logic signed [34:0] r_rs, r_xo, r_yo, r_zo, r_xn, r_yn, r_zn, r_xz, r_yz;
    logic [33:0]        r_den;
    logic [34:0]        r_rem;
    logic [30:0]        r_quo, r_dz;
    logic               r_vzero;
    logic [31:0]        r_mag;

    // result register
    logic        r_o_stop;
    logic [1:0]  r_o_count;
    logic [31:0] r_o_above_r, r_o_above_a, r_o_below_r, r_o_below_a;

    logic [31:0]        ang_w;
    logic signed [32:0] z0_w, zr_w;
    logic               flip_w;
    logic signed [53:0] xs_w, ys_w, cx_cl_w, cy_cl_w, c_w, s_w;
    logic signed [32:0] atan_w;
    logic signed [34:0] mul_a, mul_b;
    logic [30:0]        w_w;
    logic signed [65:0] sum_w;
    logic signed [65:0] mag_sum_w;
    logic [32:0]        zo_abs_w, zn_abs_w;
    logic               ge_w;
    logic [34:0]        rem_sub_w;
    logic signed [53:0] vx_w, vy_w;
    logic [1:0]         qo_w, qn_w;
    logic               zero_o_w, zero_n_w, pos_o_w, pos_n_w;
    logic               stop_w;

    // crossing test on the quadrant signs of cos(theta)
    assign qo_w     = r_last_th[31:30];
    assign qn_w     = r_th[31:30];
    assign zero_o_w = (r_last_th[29:0] == '0) && qo_w[0];
    assign zero_n_w = (r_th[29:0] == '0) && qn_w[0];
    assign pos_o_w  = qo_w[1] ~^ qo_w[0];
    assign pos_n_w  = qn_w[1] ~^ qn_w[0];

    assign o_status.fresh    = r_fresh || !r_started;
    assign o_status.crossing = zero_o_w || zero_n_w || (pos_o_w ^ pos_n_w);

    // angle reduction for the rotation pass
    always_comb begin
        case (i_cmd.ang_sel)
            dpcs_pkg::ANG_LAST_POLAR: ang_w = r_last_th;
            dpcs_pkg::ANG_LAST_AZ:    ang_w = r_last_ph;
            dpcs_pkg::ANG_POLAR:      ang_w = r_th;
            default:                  ang_w = r_ph;
        endcase
        z0_w   = $signed({ang_w[31], ang_w});
        flip_w = 1'b0;
        zr_w   = z0_w;
        if (z0_w > dpcs_pkg::Q30_Z) begin
            zr_w   = z0_w - dpcs_pkg::HALF_Z;
            flip_w = 1'b1;
        end else if (z0_w < -dpcs_pkg::Q30_Z) begin
            zr_w   = z0_w + dpcs_pkg::HALF_Z;
            flip_w = 1'b1;
        end
    end

    assign xs_w   = r_cx >>> i_cmd.step;
    assign ys_w   = r_cy >>> i_cmd.step;
    assign atan_w = $signed({1'b0, dpcs_pkg::atan_entry(i_cmd.step)});

    // clamp and sign fix of the rotation result
    always_comb begin
        if (r_cx[53]) begin
            cx_cl_w = '0;
        end else if (r_cx > dpcs_pkg::Q30_W) begin
            cx_cl_w = dpcs_pkg::Q30_W;
        end else begin
            cx_cl_w = r_cx;
        end
        if (r_cy > dpcs_pkg::Q30_W) begin
            cy_cl_w = dpcs_pkg::Q30_W;
        end else if (r_cy < -dpcs_pkg::Q30_W) begin
            cy_cl_w = -dpcs_pkg::Q30_W;
        end else begin
            cy_cl_w = r_cy;
        end
        c_w = r_flip ? -cx_cl_w : cx_cl_w;
        s_w = r_flip ? -cy_cl_w : cy_cl_w;
    end

    assign w_w = dpcs_pkg::ONE_DZ - r_dz;

    // multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            dpcs_pkg::MUL_RS_OLD: begin
                mul_a = $signed({3'b0, r_last_r});
                mul_b = 35'(r_sin[dpcs_pkg::ANG_LAST_POLAR]);
            end
            dpcs_pkg::MUL_XO: begin
                mul_a = r_rs;
                mul_b = 35'(r_cos[dpcs_pkg::ANG_LAST_AZ]);
            end
            dpcs_pkg::MUL_YO: begin
                mul_a = r_rs;
                mul_b = 35'(r_sin[dpcs_pkg::ANG_LAST_AZ]);
            end
            dpcs_pkg::MUL_ZO: begin
                mul_a = $signed({3'b0, r_last_r});
                mul_b = 35'(r_cos[dpcs_pkg::ANG_LAST_POLAR]);
            end
            dpcs_pkg::MUL_RS_NEW: begin
                mul_a = $signed({3'b0, r_r});
                mul_b = 35'(r_sin[dpcs_pkg::ANG_POLAR]);
            end
            dpcs_pkg::MUL_XN: begin
                mul_a = r_rs;
                mul_b = 35'(r_cos[dpcs_pkg::ANG_AZ]);
            end
            dpcs_pkg::MUL_YN: begin
                mul_a = r_rs;
                mul_b = 35'(r_sin[dpcs_pkg::ANG_AZ]);
            end
            dpcs_pkg::MUL_ZN: begin
                mul_a = $signed({3'b0, r_r});
                mul_b = 35'(r_cos[dpcs_pkg::ANG_POLAR]);
            end
            dpcs_pkg::MUL_PXN: begin
                mul_a = r_xn;
                mul_b = $signed({4'b0, r_dz});
            end
            dpcs_pkg::MUL_XZ: begin
                mul_a = r_xo;
                mul_b = $signed({4'b0, w_w});
            end
            dpcs_pkg::MUL_PYN: begin
                mul_a = r_yn;
                mul_b = $signed({4'b0, r_dz});
            end
            dpcs_pkg::MUL_YZ: begin
                mul_a = r_yo;
                mul_b = $signed({4'b0, w_w});
            end
            dpcs_pkg::MUL_MAG_HI: begin
                mul_a = $signed({11'b0, r_cx[53:30]});
                mul_b = $signed(dpcs_pkg::INV_GAIN);
            end
            default: begin
                mul_a = $signed({5'b0, r_cx[29:0]});
                mul_b = $signed(dpcs_pkg::INV_GAIN);
            end
        endcase
    end

    assign sum_w     = r_acc + 66'(r_prod);
    assign mag_sum_w = r_acc + 66'(r_prod >>> 30);

    assign zo_abs_w  = r_zo[34] ? 33'(-r_zo) : 33'(r_zo);
    assign zn_abs_w  = r_zn[34] ? 33'(-r_zn) : 33'(r_zn);
    assign ge_w      = r_rem >= {1'b0, r_den};
    assign rem_sub_w = ge_w ? (r_rem - {1'b0, r_den}) : r_rem;

    assign vx_w = 54'(r_xz) <<< 16;
    assign vy_w = 54'(r_yz) <<< 16;

    assign stop_w = ((r_r > r_outer) && r_inward)
                 || ({8'b0, r_r, 8'b0} < r_inner_lim)
                 || (r_count == 2'd1);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer       <= dpcs_pkg::OUTER_RESET;
            r_inner_scale <= dpcs_pkg::INNER_RESET;
            r_horizon     <= dpcs_pkg::HORIZON_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dpcs_pkg::REG_OUTER:   r_outer       <= i_cfg_data;
                dpcs_pkg::REG_INNER:   r_inner_scale <= i_cfg_data[15:0];
                dpcs_pkg::REG_HORIZON: r_horizon     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_inner_lim <= r_inner_scale * r_horizon;
    end

    // ray state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_count   <= '0;
            r_last_r  <= '0;
            r_last_th <= '0;
            r_last_ph <= '0;
            r_above_r <= dpcs_pkg::NONE_RADIUS;
            r_above_a <= '0;
            r_below_r <= dpcs_pkg::NONE_RADIUS;
            r_below_a <= '0;
        end else begin
            case (i_cmd.op)
                dpcs_pkg::OP_FRESH: begin
                    r_started <= 1'b1;
                    r_count   <= '0;
                    r_above_r <= dpcs_pkg::NONE_RADIUS;
                    r_above_a <= '0;
                    r_below_r <= dpcs_pkg::NONE_RADIUS;
                    r_below_a <= '0;
                    r_last_r  <= r_r;
                    r_last_th <= r_th;
                    r_last_ph <= r_ph;
                end
                dpcs_pkg::OP_PLAIN: begin
                    r_last_r  <= r_r;
                    r_last_th <= r_th;
                    r_last_ph <= r_ph;
                end
                dpcs_pkg::OP_CROSS: begin
                    if (r_count != 2'd3) begin
                        r_count <= r_count + 2'd1;
                    end
                    if ((r_above_r > dpcs_pkg::FREE_LIMIT) && !r_zo[34]
                        && (r_zn[34] || (r_zn == '0))) begin
                        r_above_r <= r_vzero ? '0 : r_mag;
                        r_above_a <= r_vzero ? '0 : r_cz[31:0];
                    end
                    if ((r_below_r > dpcs_pkg::FREE_LIMIT) && !r_zn[34]
                        && (r_zo[34] || (r_zo == '0))) begin
                        r_below_r <= r_vzero ? '0 : r_mag;
                        r_below_a <= r_vzero ? '0 : r_cz[31:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // word latch, arithmetic units and result register
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            dpcs_pkg::OP_LOAD: begin
                r_fresh  <= i_new_ray;
                r_r      <= i_radius;
                r_th     <= i_polar_angle;
                r_ph     <= i_azimuth;
                r_inward <= i_moving_inward;
            end
            dpcs_pkg::OP_ROT_INIT: begin
                r_cx    <= $signed({19'b0, dpcs_pkg::INV_GAIN});
                r_cy    <= '0;
                r_cz    <= zr_w;
                r_flip  <= flip_w;
                r_exact <= (ang_w[29:0] == '0);
                r_quad  <= ang_w[31:30];
            end
            dpcs_pkg::OP_ROT_STEP: begin
                if (!r_cz[32]) begin
                    r_cx <= r_cx - ys_w;
                    r_cy <= r_cy + xs_w;
                    r_cz <= r_cz - atan_w;
                end else begin
                    r_cx <= r_cx + ys_w;
                    r_cy <= r_cy - xs_w;
                    r_cz <= r_cz + atan_w;
                end
            end
            dpcs_pkg::OP_ROT_SAVE: begin
                if (r_exact) begin
                    case (r_quad)
                        2'd0: begin
                            r_cos[i_cmd.ang_sel] <= dpcs_pkg::ONE_Q30;
                            r_sin[i_cmd.ang_sel] <= '0;
                        end
                        2'd1: begin
                            r_cos[i_cmd.ang_sel] <= '0;
                            r_sin[i_cmd.ang_sel] <= dpcs_pkg::ONE_Q30;
                        end
                        2'd2: begin
                            r_cos[i_cmd.ang_sel] <= -dpcs_pkg::ONE_Q30;
                            r_sin[i_cmd.ang_sel] <= '0;
                        end
                        default: begin
                            r_cos[i_cmd.ang_sel] <= '0;
                            r_sin[i_cmd.ang_sel] <= -dpcs_pkg::ONE_Q30;
                        end
                    endcase
                end else begin
                    r_cos[i_cmd.ang_sel] <= 32'(c_w);
                    r_sin[i_cmd.ang_sel] <= 32'(s_w);
                end
            end
            dpcs_pkg::OP_MUL: begin
                r_prod <= mul_a * mul_b;
            end
            dpcs_pkg::OP_MUL_WB: begin
                case (i_cmd.mul_sel)
                    dpcs_pkg::MUL_RS_OLD, dpcs_pkg::MUL_RS_NEW:
                        r_rs <= 35'(r_prod >>> 30);
                    dpcs_pkg::MUL_XO: r_xo <= 35'(r_prod >>> 30);
                    dpcs_pkg::MUL_YO: r_yo <= 35'(r_prod >>> 30);
                    dpcs_pkg::MUL_ZO: r_zo <= 35'(r_prod >>> 30);
                    dpcs_pkg::MUL_XN: r_xn <= 35'(r_prod >>> 30);
                    dpcs_pkg::MUL_YN: r_yn <= 35'(r_prod >>> 30);
                    dpcs_pkg::MUL_ZN: r_zn <= 35'(r_prod >>> 30);
                    dpcs_pkg::MUL_PXN, dpcs_pkg::MUL_PYN, dpcs_pkg::MUL_MAG_HI:
                        r_acc <= 66'(r_prod);
                    dpcs_pkg::MUL_XZ: r_xz <= 35'(sum_w >>> 30);
                    dpcs_pkg::MUL_YZ: r_yz <= 35'(sum_w >>> 30);
                    default: begin
                        if (mag_sum_w[65:48] != '0) begin
                            r_mag <= dpcs_pkg::NONE_RADIUS;
                        end else begin
                            r_mag <= mag_sum_w[47:16];
                        end
                    end
                endcase
            end
            dpcs_pkg::OP_DIV_INIT: begin
                r_rem <= {2'b0, zo_abs_w};
                r_den <= {1'b0, zo_abs_w} + {1'b0, zn_abs_w};
                r_quo <= '0;
            end
            dpcs_pkg::OP_DIV_STEP: begin
                r_quo <= {r_quo[29:0], ge_w};
                r_rem <= {rem_sub_w[33:0], 1'b0};
            end
            dpcs_pkg::OP_DIV_SAVE: begin
                r_dz <= (r_den == '0) ? '0 : r_quo;
            end
            dpcs_pkg::OP_VEC_INIT: begin
                r_vzero <= (r_xz == '0) && (r_yz == '0);
                if (r_xz[34]) begin
                    r_cx <= -vx_w;
                    r_cy <= -vy_w;
                    r_cz <= {1'b0, dpcs_pkg::HALF_TURN};
                end else begin
                    r_cx <= vx_w;
                    r_cy <= vy_w;
                    r_cz <= '0;
                end
            end
            dpcs_pkg::OP_VEC_STEP: begin
                if (!r_cy[53] && (r_cy != '0)) begin
                    r_cx <= r_cx + ys_w;
                    r_cy <= r_cy - xs_w;
                    r_cz <= {1'b0, r_cz[31:0] + atan_w[31:0]};
                end else begin
                    r_cx <= r_cx - ys_w;
                    r_cy <= r_cy + xs_w;
                    r_cz <= {1'b0, r_cz[31:0] - atan_w[31:0]};
                end
            end
            dpcs_pkg::OP_PUB: begin
                r_o_stop    <= stop_w;
                r_o_count   <= r_count;
                r_o_above_r <= r_above_r;
                r_o_above_a <= r_above_a;
                r_o_below_r <= r_below_r;
                r_o_below_a <= r_below_a;
            end
            default: ;
        endcase
    end

    assign o_stop              = r_o_stop;
    assign o_crossing_total    = r_o_count;
    assign o_above_hit_radius  = r_o_above_r;
    assign o_above_hit_azimuth = $signed(r_o_above_a);
    assign o_below_hit_radius  = r_o_below_r;
    assign o_below_hit_azimuth = $signed(r_o_below_a);

endmodule

[rtl/disk_plane_crossing_stop.sv]
// ----------------------------------------------------------------------------
// disk_plane_crossing_stop
// Stop test and equatorial crossing recorder for one integrated ray.
// ----------------------------------------------------------------------------
// no-crossing step: load, decide, then publish the result word
// crossing step: four 24-step cordic sin/cos passes, a 31-step divider,
//   a vectoring pass and 14 multiplies before the result is published
// throughput: one word in flight; next word accepted once the result is registered
// reset: synchronous active low, clears ray state and loads register defaults
module disk_plane_crossing_stop (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dpcs_in_if.sink     i_in,
    dpcs_out_if.source  o_out,
    dpcs_cfg_if.sink    i_cfg
);

    dpcs_pkg::t_cmd    cmd;
    dpcs_pkg::t_status status;

    assign i_cfg.ready = 1'b1;

    dpcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dpcs_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_new_ray           (i_in.new_ray),
        .i_radius            (i_in.radius),
        .i_polar_angle       (i_in.polar_angle),
        .i_azimuth           (i_in.azimuth),
        .i_moving_inward     (i_in.moving_inward),
        .i_cfg_valid         (i_cfg.valid),
        .i_cfg_index         (i_cfg.index),
        .i_cfg_data          (i_cfg.data),
        .o_stop              (o_out.stop),
        .o_crossing_total    (o_out.crossing_total),
        .o_above_hit_radius  (o_out.above_hit_radius),
        .o_above_hit_azimuth (o_out.above_hit_azimuth),
        .o_below_hit_radius  (o_out.below_hit_radius),
        .o_below_hit_azimuth (o_out.below_hit_azimuth)
    );

endmodule

[rtl/dpcs_checker.sv]
// ----------------------------------------------------------------------------
// dpcs_checker
// Port-level checks of the disk plane crossing stop block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpcs_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_stop,
    input logic [1:0]  i_crossing_total,
    input logic [31:0] i_above_hit_radius,
    input logic [31:0] i_above_hit_azimuth,
    input logic [31:0] i_below_hit_radius,
    input logic [31:0] i_below_hit_azimuth
);

    // stalled result word holds valid, stop, crossing total and both hit radii
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_stop) && $stable(i_crossing_total) && $stable(i_above_hit_radius) && $stable(i_below_hit_radius))

    // one word in flight
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // no crossing means no hits recorded
    `ASSERT_NOW(a_no_cross_no_hit, i_clk, i_rst_n, i_out_valid && (i_crossing_total == 2'd0), (i_above_hit_radius == 32'hFFFF_FFFF) && (i_below_hit_radius == 32'hFFFF_FFFF) && (i_above_hit_azimuth == 32'd0) && (i_below_hit_azimuth == 32'd0))

    // reset empties the result register
    `ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !i_out_valid)

endmodule

bind disk_plane_crossing_stop dpcs_port_checks u_dpcs_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_stop              (o_out.stop),
    .i_crossing_total    (o_out.crossing_total),
    .i_above_hit_radius  (o_out.above_hit_radius),
    .i_above_hit_azimuth (o_out.above_hit_azimuth),
    .i_below_hit_radius  (o_out.below_hit_radius),
    .i_below_hit_azimuth (o_out.below_hit_azimuth)
);
